[hdl/deq_pkg.sv]
// Package: shared types, codes and constants of the double-ended queue.
package deq_pkg;

    // Default number of word slots in the ring store
    localparam int DEPTH_DEFAULT = 16;

    // Field widths of one command item and one result item
    localparam int CMD_W    = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Packed stream widths, padded to whole bytes
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 72;
    localparam int M_USED_W = STATUS_W + 2 * WORD_W + COUNT_W;

    // Command codes; codes above peek behave as peek
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_REVERSE    = 3'd4,
        CMD_PEEK       = 3'd5
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

[hdl/deq_skid.sv]
// Two-entry output buffer that decouples the result register from the stream sink.
module deq_skid import deq_pkg::*; #(
    parameter int W = M_DATA_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_valid_reg;
    logic [W-1:0] out_data_reg;
    logic         sk_valid_reg;
    logic [W-1:0] sk_data_reg;
    logic         out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = !sk_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Advance the output slot from the skid slot first, else from the input
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sk_valid_reg  <= 1'b0;
        end else if (out_free) begin
            if (sk_valid_reg) begin
                out_valid_reg <= 1'b1;
                sk_valid_reg  <= 1'b0;
            end else begin
                out_valid_reg <= in_valid;
            end
        end else if (in_valid && in_ready) begin
            sk_valid_reg <= 1'b1;
        end
    end

    // Move payload alongside the valid bits
    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (sk_valid_reg) begin
                out_data_reg <= sk_data_reg;
            end else if (in_valid) begin
                out_data_reg <= in_data;
            end
        end else if (in_valid && in_ready) begin
            sk_data_reg <= in_data;
        end
    end

endmodule

[hdl/double_ended_queue.sv]
// A result item reaches m_ through the result register and then the output buffer.
// One command item per cycle unless stalled; the ring store has one write and two read
// ports. The result register feeds a two-entry output buffer, so input keeps flowing
// while a result waits. Reset clears head index, count, reversal flag and all valid
// bits; the ring store is not cleared, only occupied slots are ever reported.
module double_ended_queue import deq_pkg::*; #(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // command[2:0], value[34:3], zero pad
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status[1:0], front_value[33:2],
                                           // back_value[65:34], count[70:66], zero pad
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = AW + 2;
    localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
    localparam logic [SW-1:0] DEPTH_S   = SW'(DEPTH);

    // Ring store
    logic [WORD_W-1:0] slots [DEPTH];

    // Queue state
    logic [AW-1:0] first_reg, first_next;
    logic [CW-1:0] held_reg, held_next;
    logic          rev_reg, rev_next;

    // Result stage
    logic              st_valid_reg;
    status_t           st_status_reg;
    logic              st_empty_reg;
    logic              st_rev_reg;
    logic [CW-1:0]     st_held_reg;
    logic [WORD_W-1:0] st_head_reg;
    logic [WORD_W-1:0] st_tail_reg;

    // Command decode and write port
    cmd_t              cmd;
    logic [WORD_W-1:0] val;
    logic              s_acc;
    logic              is_push;
    logic              is_pop;
    status_t           status;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     first_inc;
    logic [AW-1:0]     first_dec;
    logic [SW-1:0]     tail_sum;
    logic [AW-1:0]     tail_slot;
    logic [SW-1:0]     last_sum;
    logic [AW-1:0]     last_next;
    logic              at_tail;

    // Output side
    logic              sk_ready;
    logic [WORD_W-1:0] front_word;
    logic [WORD_W-1:0] back_word;
    logic [M_DATA_W-1:0] st_data;

    assign cmd      = cmd_t'(s_tdata[CMD_W-1:0]);
    assign val      = s_tdata[CMD_W +: WORD_W];
    assign s_tready = !st_valid_reg || sk_ready;
    assign s_acc    = s_tvalid && s_tready;
    assign is_push  = (cmd == CMD_PUSH_BACK) || (cmd == CMD_PUSH_FRONT);
    assign is_pop   = (cmd == CMD_POP_BACK) || (cmd == CMD_POP_FRONT);

    // Wrap the head index one step either way
    assign first_inc = (first_reg == LAST_SLOT) ? '0 : first_reg + AW'(1);
    assign first_dec = (first_reg == '0) ? LAST_SLOT : first_reg - AW'(1);

    // Physical slot just past the tail
    assign tail_sum  = SW'(first_reg) + SW'(held_reg);
    assign tail_slot = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);

    // Decode the command and update the ring pointers
    always_comb begin
        first_next = first_reg;
        held_next  = held_reg;
        rev_next   = rev_reg;
        status     = ST_DONE;
        we         = 1'b0;
        waddr      = tail_slot;
        at_tail    = 1'b0;
        unique case (cmd) inside
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (held_reg == FULL_CNT) begin
                    status = ST_FULL;
                end else begin
                    at_tail   = (cmd == CMD_PUSH_BACK) != rev_reg;
                    we        = 1'b1;
                    held_next = held_reg + CW'(1);
                    if (!at_tail) begin
                        first_next = first_dec;
                        waddr      = first_dec;
                    end
                end
            end
            CMD_POP_BACK, CMD_POP_FRONT: begin
                if (held_reg == '0) begin
                    status = ST_EMPTY;
                end else begin
                    at_tail   = (cmd == CMD_POP_BACK) != rev_reg;
                    held_next = held_reg - CW'(1);
                    if (!at_tail) begin
                        first_next = first_inc;
                    end
                end
            end
            CMD_REVERSE: begin
                rev_next = !rev_reg;
            end
            default: begin
            end
        endcase
    end

    // Physical index of the last word after the command
    assign last_sum  = SW'(first_next) + SW'(held_next) - SW'(1);
    assign last_next = (last_sum >= DEPTH_S) ? AW'(last_sum - DEPTH_S) : AW'(last_sum);

    // Hold queue state and stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg    <= '0;
            held_reg     <= '0;
            rev_reg      <= 1'b0;
            st_valid_reg <= 1'b0;
        end else begin
            if (s_acc) begin
                first_reg <= first_next;
                held_reg  <= held_next;
                rev_reg   <= rev_next;
            end
            if (s_acc) begin
                st_valid_reg <= 1'b1;
            end else if (sk_ready) begin
                st_valid_reg <= 1'b0;
            end
        end
    end

    // Write the pushed word and read both ends, forwarding a same-cycle write
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            if (we) begin
                slots[waddr] <= val;
            end
            st_head_reg   <= (we && waddr == first_next) ? val : slots[first_next];
            st_tail_reg   <= (we && waddr == last_next) ? val : slots[last_next];
            st_status_reg <= status;
            st_empty_reg  <= (held_next == '0);
            st_rev_reg    <= rev_next;
            st_held_reg   <= held_next;
        end
    end

    // Map physical ends to logical front and back
    always_comb begin
        if (st_empty_reg) begin
            front_word = '1;
            back_word  = '1;
        end else if (st_rev_reg) begin
            front_word = st_tail_reg;
            back_word  = st_head_reg;
        end else begin
            front_word = st_head_reg;
            back_word  = st_tail_reg;
        end
    end

    assign st_data = {{(M_DATA_W - M_USED_W){1'b0}}, COUNT_W'(st_held_reg),
                      back_word, front_word, st_status_reg};

    deq_skid #(
        .W (M_DATA_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (st_valid_reg),
        .in_ready  (sk_ready),
        .in_data   (st_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    // Count never exceeds capacity
    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        held_reg <= FULL_CNT)
        else $error("held count above capacity");

    // Push on full is refused and leaves the count alone
    a_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && is_push && held_reg == FULL_CNT
        |=> st_status_reg == ST_FULL && held_reg == $past(held_reg))
        else $error("push on full not refused");

    // Pop on empty is refused and reports an empty queue
    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && is_pop && held_reg == '0
        |=> st_status_reg == ST_EMPTY && st_empty_reg && held_reg == '0)
        else $error("pop on empty not refused");

    // A stalled result stage keeps its item
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && !sk_ready |=> st_valid_reg && $stable(st_held_reg))
        else $error("result stage lost a stalled item");

endmodule

[tb/tb_double_ended_queue.sv]
// Testbench for double_ended_queue: predicts each command's result and checks it.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import deq_pkg::*;

    // Command codes past peek, which the block treats as peek
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam int PAD_W = S_DATA_W - CMD_W - WORD_W;
    localparam logic [WORD_W-1:0] EMPTY_WORD = '1;
    localparam int RANDOM_ITEMS = 1900;

    typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_t;

    typedef struct {
        status_t           status;
        logic [WORD_W-1:0] front_word;
        logic [WORD_W-1:0] back_word;
        logic [COUNT_W-1:0] count;
    } deq_result_t;

    // Mirror of the ring store plus the results still owed by the block
    class deque_ledger;
        logic [WORD_W-1:0] ring [DEPTH_DEFAULT];
        int                head_slot;
        int                held;
        bit                flipped;
        deq_result_t       owed [$];
        int                failures;

        function new();
            head_slot = 0;
            held      = 0;
            flipped   = 1'b0;
            failures  = 0;
        endfunction

        function int outstanding();
            return owed.size();
        endfunction

        // Apply one accepted command and queue the result it must produce
        function void apply_command(logic [CMD_W-1:0] code, logic [WORD_W-1:0] word);
            deq_result_t r;
            bit          at_tail;
            r.status     = ST_DONE;
            r.front_word = EMPTY_WORD;
            r.back_word  = EMPTY_WORD;
            case (code)
                CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                    if (held >= DEPTH_DEFAULT) begin
                        r.status = ST_FULL;
                    end else begin
                        at_tail = (code == CMD_PUSH_BACK) != flipped;
                        if (at_tail) begin
                            ring[(head_slot + held) % DEPTH_DEFAULT] = word;
                        end else begin
                            head_slot = (head_slot + DEPTH_DEFAULT - 1) % DEPTH_DEFAULT;
                            ring[head_slot] = word;
                        end
                        held++;
                    end
                end
                CMD_POP_BACK, CMD_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        at_tail = (code == CMD_POP_BACK) != flipped;
                        if (!at_tail)
                            head_slot = (head_slot + 1) % DEPTH_DEFAULT;
                        held--;
                    end
                end
                CMD_REVERSE: flipped = !flipped;
                default: ;
            endcase
            // Report the logical ends; reversal swaps physical head and tail
            if (held != 0) begin
                if (flipped) begin
                    r.front_word = ring[(head_slot + held - 1) % DEPTH_DEFAULT];
                    r.back_word  = ring[head_slot];
                end else begin
                    r.front_word = ring[head_slot];
                    r.back_word  = ring[(head_slot + held - 1) % DEPTH_DEFAULT];
                end
            end
            r.count = held[COUNT_W-1:0];
            owed.push_back(r);
        endfunction

        // Compare one accepted result item with the oldest owed result
        function void compare_result(logic [M_DATA_W-1:0] data);
            deq_result_t        want;
            logic [STATUS_W-1:0] got_status;
            logic [WORD_W-1:0]  got_front;
            logic [WORD_W-1:0]  got_back;
            logic [COUNT_W-1:0] got_count;
            got_status = data[0 +: STATUS_W];
            got_front  = data[STATUS_W +: WORD_W];
            got_back   = data[STATUS_W + WORD_W +: WORD_W];
            got_count  = data[STATUS_W + 2 * WORD_W +: COUNT_W];
            if (owed.size() == 0) begin
                $error("result item with nothing owed: data %h", data);
                failures++;
                return;
            end
            want = owed.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                failures++;
            end
            if (got_front !== want.front_word) begin
                $error("front_value: expected %h, got %h", want.front_word, got_front);
                failures++;
            end
            if (got_back !== want.back_word) begin
                $error("back_value: expected %h, got %h", want.back_word, got_back);
                failures++;
            end
            if (got_count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got_count);
                failures++;
            end
        endfunction
    endclass

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // command[2:0], value[34:3], zero pad
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // status[1:0], front_value[33:2],
                                          // back_value[65:34], count[70:66], zero pad
    bit                  steady   = 1'b0;
    deque_ledger         ledger   = new();

    double_ended_queue uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Stall the result side at random, except during the steady stretch
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 11);
    end

    // Track both handshakes in one place so ordering within an edge is fixed
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                ledger.apply_command(s_tdata[0 +: CMD_W], s_tdata[CMD_W +: WORD_W]);
            if (m_tvalid && m_tready)
                ledger.compare_result(m_tdata);
        end
    end

    // Offer one command item, with random idle cycles ahead of it
    task automatic issue(logic [CMD_W-1:0] code, logic [WORD_W-1:0] word);
        while (!steady && $urandom_range(0, 99) < 11) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{PAD_W{1'b0}}, word, code};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Hold the sender until every owed result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.outstanding() != 0) @(posedge aclk);
    endtask

    function automatic logic [CMD_W-1:0] pick_command(lean_t lean);
        int roll;
        int push_share;
        int pop_share;
        roll       = $urandom_range(0, 99);
        push_share = (lean == LEAN_FILL) ? 65 : (lean == LEAN_DRAIN) ? 20 : 38;
        pop_share  = (lean == LEAN_FILL) ? 20 : (lean == LEAN_DRAIN) ? 65 : 38;
        if (roll < push_share)
            return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        roll -= push_share;
        if (roll < pop_share)
            return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
        roll -= pop_share;
        if (roll < 8)
            return CMD_REVERSE;
        if (roll < 12)
            return CMD_PEEK;
        return $urandom_range(0, 1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        if ($urandom_range(0, 9) != 0)
            return $urandom;
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Stimulus: directed corners, then biased random phases
    initial begin
        int    sent;
        int    span;
        lean_t lean;
        bit    paused;
        sent   = 0;
        paused = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty queue: peek, refused pops, reverse with nothing held
        issue(CMD_PEEK, 32'h0);
        issue(CMD_POP_BACK, 32'hFFFF_FFFF);
        issue(CMD_POP_FRONT, 32'h0);
        issue(CMD_REVERSE, 32'h0);
        // Single word: reverse has no visible effect, pop leaves it empty
        issue(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        issue(CMD_REVERSE, 32'h0);
        issue(CMD_POP_BACK, 32'h0);
        issue(CMD_PUSH_FRONT, 32'h8000_0000);
        issue(CMD_POP_FRONT, 32'h0);
        // Mixed ends with extreme words, across a reversal
        issue(CMD_PUSH_FRONT, 32'h8000_0000);
        issue(CMD_PUSH_BACK, 32'h0000_0000);
        issue(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        issue(CMD_PUSH_BACK, 32'h7FFF_FFFF);
        issue(CMD_REVERSE, 32'h0);
        issue(CMD_PEEK, 32'h0);
        issue(CMD_PUSH_BACK, 32'h5555_5555);
        issue(CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        issue(CMD_POP_FRONT, 32'h0);
        issue(CMD_POP_BACK, 32'h0);
        issue(CMD_UNUSED_LO, 32'h1234_5678);
        issue(CMD_UNUSED_HI, 32'hFFFF_FFFF);
        issue(CMD_REVERSE, 32'h0);
        issue(CMD_POP_FRONT, 32'h0);
        drain_results();

        // Random phases leaning toward full, toward empty, or balanced
        while (sent < RANDOM_ITEMS) begin
            lean = lean_t'($urandom_range(0, 2));
            span = $urandom_range(15, 60);
            repeat (span) begin
                steady = (sent >= 700 && sent < 1000);
                if (!paused && sent >= 1200) begin
                    drain_results();
                    paused = 1'b1;
                end
                issue(pick_command(lean), pick_word());
                sent++;
            end
        end
        steady = 1'b0;

        // Wait out every owed result, then keep watching for strays
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (ledger.outstanding() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (ledger.failures == 0 && ledger.outstanding() == 0) begin
            $display("tb_double_ended_queue: clean");
        end else begin
            $display("tb_double_ended_queue: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("tb_double_ended_queue: errors");
        $finish;
    end

endmodule

[files.f]
hdl/deq_pkg.sv
hdl/deq_skid.sv
hdl/double_ended_queue.sv
tb/tb_double_ended_queue.sv
